// ===== design/assert_macros.svh =====
// Assertion macros shared by the GCR record decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define GCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define GCR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define GCR_ASSERT(lbl, prop)
`define GCR_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== design/gcrdec_pkg.sv =====
// Constants, GCR lookup table and result type for the GCR record decoder.
package gcrdec_pkg;

  localparam int unsigned SectorBytes = 256;
  // Byte counter reaches SectorBytes + 2; SectorBytes + 1 is the data checksum index.
  localparam int unsigned ByteCntW = $clog2(SectorBytes + 2);

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 6;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [3:0] BitsPerByte = 4'd10;

  localparam logic [7:0] HeaderMarkRst = 8'd8;
  localparam logic [7:0] DataMarkRst   = 8'd7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgHeaderMark = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDataMark   = 2'd1;

  // Record kinds.
  localparam logic [1:0] KindHeader  = 2'd0;
  localparam logic [1:0] KindData    = 2'd1;
  localparam logic [1:0] KindUnknown = 2'd2;

  // Record status codes, meaningful on the last byte only.
  localparam logic [2:0] StatHeaderOk  = 3'd0;
  localparam logic [2:0] StatHeaderBad = 3'd1;
  localparam logic [2:0] StatDataOk    = 3'd2;
  localparam logic [2:0] StatDataBad   = 3'd3;
  localparam logic [2:0] StatNoRecord  = 3'd4;

  // Bit 4 marks a valid 5-bit code, low nibble is the decoded value.
  localparam logic [4:0] GcrTable [32] = '{
    5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00,
    5'h00, 5'h18, 5'h10, 5'h11, 5'h00, 5'h1C, 5'h14, 5'h15,
    5'h00, 5'h00, 5'h12, 5'h13, 5'h00, 5'h1F, 5'h16, 5'h17,
    5'h00, 5'h19, 5'h1A, 5'h1B, 5'h00, 5'h1D, 5'h1E, 5'h00
  };

  typedef struct packed {
    logic [7:0] byte_value;
    logic [8:0] byte_index;
    logic [1:0] record_kind;
    logic [7:0] sector_number;
    logic [7:0] track_number;
    logic [2:0] record_status;
    logic       bad_code;
    logic       last;
  } result_t;

endpackage

// ===== design/gcr_disk_record_decoder.sv =====
// GCR disk record decoder: raw bits in, decoded record bytes out.
//
//  Channel | Dir | Handshake                    | Payload
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tdata: raw_bit; tuser: record_start
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata: byte/index/sector/track;
//          |     |                              | tuser: kind/status/bad; tlast: last
//  cfg     | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One raw bit is accepted per cycle while s_axis_tready is high; every tenth bit of a
// record yields a byte that is registered in the output stage before it shows on m_axis.
// Results go to a two-entry output stage (result register plus skid register);
// s_axis_tready drops only while both entries hold untaken results.
// Reset clears the record state and loads header_mark = 8, data_mark = 7.
// cfg_ready_o is always high; writes take effect on the next cycle.
`include "assert_macros.svh"

module gcr_disk_record_decoder
  import gcrdec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [0] raw_bit, rest zero
  input  logic [0:0]          s_axis_tuser,   // [0] record_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] byte_value, [16:8] byte_index,
                                              // [24:17] sector_number,
                                              // [32:25] track_number, rest zero
  output logic [OutUserW-1:0] m_axis_tuser,   // [1:0] record_kind,
                                              // [4:2] record_status, [5] bad_code
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  // Configuration registers.
  logic [7:0] header_mark_q, header_mark_d;
  logic [7:0] data_mark_q, data_mark_d;

  // Record state.
  logic [9:0]          bit_shift_q, bit_shift_d;
  logic [3:0]          bit_count_q, bit_count_d;
  logic [ByteCntW-1:0] byte_count_q, byte_count_d;
  logic [1:0]          kind_q, kind_d;
  logic                in_record_q, in_record_d;
  logic [7:0]          run_xor_q, run_xor_d;
  logic [7:0]          chk_q, chk_d;
  logic [7:0]          sector_q, sector_d;
  logic [7:0]          track_q, track_d;
  logic                bad_seen_q, bad_seen_d;

  // Output stage.
  result_t out_q, out_d, skid_q, skid_d, res;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic    res_valid;

  // Working values: state as seen after an optional restart.
  logic                in_fire, start, in_rec_eff, out_take;
  logic [9:0]          shift_eff, shift_new;
  logic [3:0]          cnt_eff, cnt_inc;
  logic [ByteCntW-1:0] byte_cnt_eff;
  logic [1:0]          kind_eff;
  logic [7:0]          xor_eff, chk_eff, sector_eff, track_eff;
  logic                bad_eff;
  logic [4:0]          hi_entry, lo_entry;
  logic [3:0]          hi_nib, lo_nib;
  logic [7:0]          byte_val;
  logic [2:0]          status;
  logic                last;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_take = out_valid_q & m_axis_tready;
  assign start    = s_axis_tuser[0];

  assign in_rec_eff   = start | in_record_q;
  assign shift_eff    = start ? '0 : bit_shift_q;
  assign cnt_eff      = start ? '0 : bit_count_q;
  assign byte_cnt_eff = start ? '0 : byte_count_q;
  assign kind_eff     = start ? KindHeader : kind_q;
  assign xor_eff      = start ? '0 : run_xor_q;
  assign chk_eff      = start ? '0 : chk_q;
  assign sector_eff   = start ? '0 : sector_q;
  assign track_eff    = start ? '0 : track_q;
  assign bad_eff      = start ? 1'b0 : bad_seen_q;

  assign shift_new = {shift_eff[8:0], s_axis_tdata[0]};
  assign cnt_inc   = cnt_eff + 4'd1;

  assign hi_entry = GcrTable[shift_new[9:5]];
  assign lo_entry = GcrTable[shift_new[4:0]];
  assign hi_nib   = hi_entry[4] ? hi_entry[3:0] : 4'hF;
  assign lo_nib   = lo_entry[4] ? lo_entry[3:0] : 4'hF;
  assign byte_val = {hi_nib, lo_nib};

  // Record decoding.
  always_comb begin
    bit_shift_d  = bit_shift_q;
    bit_count_d  = bit_count_q;
    byte_count_d = byte_count_q;
    kind_d       = kind_q;
    in_record_d  = in_record_q;
    run_xor_d    = run_xor_q;
    chk_d        = chk_q;
    sector_d     = sector_q;
    track_d      = track_q;
    bad_seen_d   = bad_seen_q;
    status       = StatHeaderOk;
    last         = 1'b0;
    res_valid    = 1'b0;

    if (in_fire && in_rec_eff) begin
      bit_shift_d  = shift_new;
      in_record_d  = 1'b1;
      kind_d       = kind_eff;
      run_xor_d    = xor_eff;
      chk_d        = chk_eff;
      sector_d     = sector_eff;
      track_d      = track_eff;
      bad_seen_d   = bad_eff;
      byte_count_d = byte_cnt_eff;
      if (cnt_inc < BitsPerByte) begin
        bit_count_d = cnt_inc;
      end else begin
        bit_count_d = '0;
        res_valid   = 1'b1;
        bad_seen_d  = bad_eff | ~hi_entry[4] | ~lo_entry[4];
        if (byte_cnt_eff == '0) begin
          if (byte_val == header_mark_q) begin
            kind_d = KindHeader;
          end else if (byte_val == data_mark_q) begin
            kind_d = KindData;
          end else begin
            kind_d = KindUnknown;
            status = StatNoRecord;
            last   = 1'b1;
          end
        end else if (kind_eff == KindHeader) begin
          if (byte_cnt_eff == ByteCntW'(1)) begin
            chk_d = byte_val;
          end else begin
            run_xor_d = xor_eff ^ byte_val;
            if (byte_cnt_eff == ByteCntW'(2)) begin
              sector_d = byte_val;
            end
            if (byte_cnt_eff == ByteCntW'(3)) begin
              track_d = byte_val - 8'd1;
            end
            if (byte_cnt_eff >= ByteCntW'(5)) begin
              last   = 1'b1;
              status = (run_xor_d == chk_eff) ? StatHeaderOk : StatHeaderBad;
            end
          end
        end else begin
          if (byte_cnt_eff <= ByteCntW'(SectorBytes)) begin
            run_xor_d = xor_eff ^ byte_val;
          end else begin
            last   = 1'b1;
            status = (xor_eff == byte_val) ? StatDataOk : StatDataBad;
          end
        end
        byte_count_d = byte_cnt_eff + ByteCntW'(1);
        if (last) begin
          in_record_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.byte_value    = byte_val;
    res.byte_index    = 9'(byte_cnt_eff);
    res.record_kind   = kind_d;
    res.sector_number = (kind_d == KindHeader) ? sector_d : 8'd0;
    res.track_number  = (kind_d == KindHeader) ? track_d : 8'd0;
    res.record_status = status;
    res.bad_code      = bad_seen_d;
    res.last          = last;
  end

  // Output stage: result register backed by one skid entry.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  // Configuration writes.
  always_comb begin
    header_mark_d = header_mark_q;
    data_mark_d   = data_mark_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHeaderMark: header_mark_d = cfg_data_i;
        CfgDataMark:   data_mark_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_mark_q <= HeaderMarkRst;
      data_mark_q   <= DataMarkRst;
      bit_shift_q   <= '0;
      bit_count_q   <= '0;
      byte_count_q  <= '0;
      kind_q        <= KindHeader;
      in_record_q   <= 1'b0;
      run_xor_q     <= '0;
      chk_q         <= '0;
      sector_q      <= '0;
      track_q       <= '0;
      bad_seen_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      header_mark_q <= header_mark_d;
      data_mark_q   <= data_mark_d;
      bit_shift_q   <= bit_shift_d;
      bit_count_q   <= bit_count_d;
      byte_count_q  <= byte_count_d;
      kind_q        <= kind_d;
      in_record_q   <= in_record_d;
      run_xor_q     <= run_xor_d;
      chk_q         <= chk_d;
      sector_q      <= sector_d;
      track_q       <= track_d;
      bad_seen_q    <= bad_seen_d;
      out_valid_q   <= out_valid_d;
      skid_valid_q  <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready = ~skid_valid_q;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {7'd0, out_q.track_number, out_q.sector_number,
                          out_q.byte_index, out_q.byte_value};
  assign m_axis_tuser  = {out_q.bad_code, out_q.record_status, out_q.record_kind};

  `GCR_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q)
  `GCR_ASSERT(a_bit_count_range, bit_count_q < BitsPerByte)
  `GCR_ASSERT(a_idle_no_partial, !in_record_q |-> bit_count_q == 4'd0)
  `GCR_ASSERT(a_status_only_last,
              (out_valid_q && !out_q.last) |-> out_q.record_status == StatHeaderOk)
  `GCR_ASSERT_NEVER(a_unknown_not_last,
                    out_valid_q && out_q.record_kind == KindUnknown && !out_q.last)

endmodule
